// ===== design/bfd_pkg.sv =====
package bfd_pkg;

    // Accumulator width of every forward-difference cell
    localparam int ACC_W = 56;

    // Control point registers: three packed coordinates, x in the low bits
    localparam int POINT_W      = 48;
    localparam int NUM_CTRL_PTS = 4;
    localparam int NUM_AXES     = 3;

    // Register indexes of the control points
    localparam int REG_POINT_0 = 0;
    localparam int REG_POINT_1 = 1;
    localparam int REG_POINT_2 = 2;
    localparam int REG_POINT_3 = 3;

    // Cells per axis: position, first, second and third difference
    localparam int NUM_CELLS = 4;
    localparam int NUM_DIFFS = 3;

    // Segment count and the powers of it used as divisor
    localparam int SEG_W = 6;
    localparam int N2_W  = 2 * SEG_W;
    localparam int DEN_W = 3 * SEG_W;

    // Quotient bits resolved per divider cycle
    localparam int DIV_BITS_PER_CYCLE = 2;

    // Register port
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_SUM,
        ST_START,
        ST_DIVIDE,
        ST_LOAD,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic run;
    } div_ctrl_t;

endpackage

// ===== design/bfd_cell.sv =====
module bfd_cell (
    input  logic                        aclk,
    input  bfd_pkg::cell_ctrl_t         ctrl,
    input  logic [bfd_pkg::ACC_W-1:0]   load_value,
    input  logic [bfd_pkg::ACC_W-1:0]   neighbour,
    output logic [bfd_pkg::ACC_W-1:0]   value
);

    logic [bfd_pkg::ACC_W-1:0] acc_reg;
    logic [bfd_pkg::ACC_W-1:0] acc_next;

    // Load at setup, otherwise add the neighbour's value on each step
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.load) begin
            acc_next = load_value;
        end else if (ctrl.step) begin
            acc_next = acc_reg + neighbour;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign value = acc_reg;

endmodule

// ===== design/bfd_div.sv =====
module bfd_div #(
    parameter int NUM_W     = 34,
    parameter int FRAC_BITS = 32
) (
    input  logic                        aclk,
    input  bfd_pkg::div_ctrl_t          ctrl,
    input  logic signed [NUM_W-1:0]     num,
    input  logic [bfd_pkg::DEN_W-1:0]   den,
    output logic [bfd_pkg::ACC_W-1:0]   quot
);

    localparam int DIV_STEPS = (NUM_W + FRAC_BITS + bfd_pkg::DIV_BITS_PER_CYCLE - 1)
                               / bfd_pkg::DIV_BITS_PER_CYCLE;
    localparam int DVD_W     = bfd_pkg::DIV_BITS_PER_CYCLE * DIV_STEPS;

    logic [DVD_W-1:0]            dvd_reg;
    logic [DVD_W-1:0]            dvd_next;
    logic [bfd_pkg::DEN_W-1:0]   rem_reg;
    logic [bfd_pkg::DEN_W-1:0]   rem_next;
    logic [bfd_pkg::ACC_W-1:0]   quo_reg;
    logic [bfd_pkg::ACC_W-1:0]   quo_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [NUM_W-1:0]            mag;
    logic [bfd_pkg::DEN_W:0]     rem_sh;
    logic [bfd_pkg::DEN_W:0]     rem_dbl;
    logic                        round_up;

    // Magnitude of the numerator; the most negative value maps correctly
    assign mag = num[NUM_W-1] ? (~num + 1'b1) : num;

    // Restoring division of mag * 2^FRAC_BITS, a few quotient bits a cycle.
    // Only the low accumulator bits of the quotient are kept.
    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        rem_sh   = '0;
        if (ctrl.start) begin
            dvd_next = DVD_W'(mag) << FRAC_BITS;
            rem_next = '0;
            quo_next = '0;
            neg_next = num[NUM_W-1];
        end else if (ctrl.run) begin
            for (int i = 0; i < bfd_pkg::DIV_BITS_PER_CYCLE; i++) begin
                rem_sh   = {rem_next, dvd_next[DVD_W-1]};
                dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, den}) begin
                    rem_next = bfd_pkg::DEN_W'(rem_sh - {1'b0, den});
                    quo_next = {quo_next[bfd_pkg::ACC_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[bfd_pkg::DEN_W-1:0];
                    quo_next = {quo_next[bfd_pkg::ACC_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // Round half away from zero, then apply the sign: -(q + c) = ~q + 1 - c
    assign rem_dbl  = {rem_reg, 1'b0};
    assign round_up = (rem_dbl >= {1'b0, den});

    always_comb begin
        if (neg_reg) begin
            quot = round_up ? ~quo_reg : (~quo_reg + bfd_pkg::ACC_W'(1));
        end else begin
            quot = quo_reg + bfd_pkg::ACC_W'(round_up);
        end
    end

endmodule

// ===== design/bezier_forward_difference.sv =====
// Cubic Bezier tessellator. Four control points are written over the register
// port (64-bit words at byte addresses 0, 8, 16 and 24, each holding x, y and z
// as signed COORD_BITS fields from the low end). A request carries a segment
// count n, clipped to MAX_SEGMENTS, and the block returns n + 1 curve points
// from the start point to the end point, with step_index counting from zero
// and last set on the final point. Coordinates are rounded to the nearest
// integer and saturated. Requests are handled one at a time: setup forms the
// coefficient products and the numerators, then runs the bank of nine serial
// dividers that form the differences from 1/n^3 at two quotient bits per
// cycle, and loads the cells; the chain of accumulator cells then yields one
// point per cycle while the output is taken. For zero segments the dividers
// are skipped. The next request is taken while the final point still waits in
// the output register.
module bezier_forward_difference #(
    parameter int MAX_SEGMENTS = 63,
    parameter int COORD_BITS   = 16,
    parameter int FRAC_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfd_pkg::ADDR_W-1:0]          paddr,
    input  logic [bfd_pkg::DATA_W-1:0]          pwdata,
    output logic [bfd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bfd_pkg::SEG_W-1:0]           s_segments,
    // point channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [COORD_BITS-1:0]        m_out_x,
    output logic signed [COORD_BITS-1:0]        m_out_y,
    output logic signed [COORD_BITS-1:0]        m_out_z,
    output logic [bfd_pkg::SEG_W-1:0]           m_step_index,
    output logic                                m_last
);

    localparam int ACC_W     = bfd_pkg::ACC_W;
    localparam int SEG_W     = bfd_pkg::SEG_W;
    localparam int COEF_W    = COORD_BITS + 4;
    localparam int PA_W      = COEF_W + SEG_W + 1;
    localparam int PB_W      = COEF_W + bfd_pkg::N2_W + 1;
    localparam int NUM_W     = COORD_BITS + 18;
    localparam int PT_EXT_W  = (3 * COORD_BITS > bfd_pkg::POINT_W) ? 3 * COORD_BITS
                                                                    : bfd_pkg::POINT_W;
    localparam int DIV_STEPS = (NUM_W + FRAC_BITS + bfd_pkg::DIV_BITS_PER_CYCLE - 1)
                               / bfd_pkg::DIV_BITS_PER_CYCLE;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int IDX_HI    = bfd_pkg::ADDR_W - 1;

    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W:0] CO_HI    =
        (ACC_W + 1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W:0] CO_LO    = ~CO_HI;

    // Accumulator to integer coordinate: round half up, then saturate
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] sh;
        logic signed [COORD_BITS-1:0] res;
        v  = $signed({acc[ACC_W-1], acc}) + RND_HALF;
        sh = v >>> FRAC_BITS;
        if (sh > CO_HI) begin
            res = CO_HI[COORD_BITS-1:0];
        end else if (sh < CO_LO) begin
            res = CO_LO[COORD_BITS-1:0];
        end else begin
            res = sh[COORD_BITS-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Control point registers
    // ------------------------------------------------------------------
    logic [bfd_pkg::POINT_W-1:0] point_reg [bfd_pkg::NUM_CTRL_PTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < bfd_pkg::NUM_CTRL_PTS; j++) begin
                point_reg[j] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            point_reg[paddr[IDX_HI:3]] <= pwdata[bfd_pkg::POINT_W-1:0];
        end
    end

    assign prdata = bfd_pkg::DATA_W'(point_reg[paddr[IDX_HI:3]]);
    assign pready = 1'b1;

    // Unpacked coordinates; register bits above the three fields read as zero
    logic [PT_EXT_W-1:0]         pt_ext [bfd_pkg::NUM_CTRL_PTS];
    logic signed [COORD_BITS-1:0] coord [bfd_pkg::NUM_CTRL_PTS][bfd_pkg::NUM_AXES];

    always_comb begin
        for (int j = 0; j < bfd_pkg::NUM_CTRL_PTS; j++) begin
            pt_ext[j] = PT_EXT_W'(point_reg[j]);
            for (int a = 0; a < bfd_pkg::NUM_AXES; a++) begin
                coord[j][a] = pt_ext[j][a*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // Polynomial coefficients per axis
    logic signed [COEF_W-1:0] a1_now [bfd_pkg::NUM_AXES];
    logic signed [COEF_W-1:0] a2_now [bfd_pkg::NUM_AXES];
    logic signed [COEF_W-1:0] a3_now [bfd_pkg::NUM_AXES];

    always_comb begin
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
        logic signed [COEF_W-1:0] d10;
        logic signed [COEF_W-1:0] d210;
        for (int a = 0; a < bfd_pkg::NUM_AXES; a++) begin
            c0        = COEF_W'(coord[bfd_pkg::REG_POINT_0][a]);
            c1        = COEF_W'(coord[bfd_pkg::REG_POINT_1][a]);
            c2        = COEF_W'(coord[bfd_pkg::REG_POINT_2][a]);
            c3        = COEF_W'(coord[bfd_pkg::REG_POINT_3][a]);
            d10       = c1 - c0;
            d210      = c2 - (c1 <<< 1) + c0;
            a1_now[a] = (d10 <<< 1) + d10;
            a2_now[a] = (d210 <<< 1) + d210;
            a3_now[a] = c3 - ((c2 <<< 1) + c2) + ((c1 <<< 1) + c1) - c0;
        end
    end

    // Segment count, clipped
    logic [SEG_W-1:0]        n_sat;
    logic [bfd_pkg::N2_W-1:0] n_sq;

    always_comb begin
        if (int'(s_segments) > MAX_SEGMENTS) begin
            n_sat = SEG_W'(MAX_SEGMENTS);
        end else begin
            n_sat = s_segments;
        end
        n_sq = bfd_pkg::N2_W'(n_sat) * bfd_pkg::N2_W'(n_sat);
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    bfd_pkg::state_t     state_reg;
    bfd_pkg::state_t     state_next;
    logic [CNT_W-1:0]    div_cnt_reg;
    logic [CNT_W-1:0]    div_cnt_next;
    logic [SEG_W-1:0]    idx_reg;
    logic [SEG_W-1:0]    idx_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                slot_free;
    logic                emit;
    bfd_pkg::cell_ctrl_t cell_ctrl;
    bfd_pkg::div_ctrl_t  div_ctrl;

    logic [SEG_W-1:0]         n_reg;
    logic [bfd_pkg::N2_W-1:0] n2_reg;
    logic [bfd_pkg::DEN_W-1:0] n3_reg;

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfd_pkg::ST_IDLE;
            div_cnt_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        idx_next     = idx_reg;
        s_ready      = 1'b0;
        emit         = 1'b0;
        cell_ctrl    = '0;
        div_ctrl     = '0;
        unique case (state_reg)
            bfd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = bfd_pkg::ST_COEF;
                end
            end
            bfd_pkg::ST_COEF: begin
                state_next = bfd_pkg::ST_SUM;
            end
            bfd_pkg::ST_SUM: begin
                // zero segments: differences are cleared, no division
                state_next = (n_reg == '0) ? bfd_pkg::ST_LOAD : bfd_pkg::ST_START;
            end
            bfd_pkg::ST_START: begin
                div_ctrl.start = 1'b1;
                div_cnt_next   = '0;
                state_next     = bfd_pkg::ST_DIVIDE;
            end
            bfd_pkg::ST_DIVIDE: begin
                div_ctrl.run = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = bfd_pkg::ST_LOAD;
                end
            end
            bfd_pkg::ST_LOAD: begin
                cell_ctrl.load = 1'b1;
                idx_next       = '0;
                state_next     = bfd_pkg::ST_RUN;
            end
            bfd_pkg::ST_RUN: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (idx_reg == n_reg) begin
                        state_next = bfd_pkg::ST_IDLE;
                    end else begin
                        cell_ctrl.step = 1'b1;
                        idx_next       = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = bfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Setup datapath: coefficient products, then the numerators
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] a1_reg   [bfd_pkg::NUM_AXES];
    logic signed [COEF_W-1:0] a2_reg   [bfd_pkg::NUM_AXES];
    logic signed [COEF_W-1:0] a3_reg   [bfd_pkg::NUM_AXES];
    logic signed [PA_W-1:0]   pa2n_reg [bfd_pkg::NUM_AXES];
    logic signed [PB_W-1:0]   pa1n2_reg [bfd_pkg::NUM_AXES];
    logic signed [NUM_W-1:0]  num_reg  [bfd_pkg::NUM_AXES][bfd_pkg::NUM_DIFFS];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            n_reg  <= n_sat;
            n2_reg <= n_sq;
            for (int a = 0; a < bfd_pkg::NUM_AXES; a++) begin
                a1_reg[a] <= a1_now[a];
                a2_reg[a] <= a2_now[a];
                a3_reg[a] <= a3_now[a];
            end
        end
        if (state_reg == bfd_pkg::ST_COEF) begin
            n3_reg <= bfd_pkg::DEN_W'(n2_reg) * bfd_pkg::DEN_W'(n_reg);
            for (int a = 0; a < bfd_pkg::NUM_AXES; a++) begin
                pa2n_reg[a]  <= PA_W'(a2_reg[a]) * PA_W'($signed({1'b0, n_reg}));
                pa1n2_reg[a] <= PB_W'(a1_reg[a]) * PB_W'($signed({1'b0, n2_reg}));
            end
        end
        if (state_reg == bfd_pkg::ST_SUM) begin
            for (int a = 0; a < bfd_pkg::NUM_AXES; a++) begin
                // A3 + A2 n + A1 n^2,  6 A3 + 2 A2 n,  6 A3
                num_reg[a][0] <= NUM_W'(a3_reg[a]) + NUM_W'(pa2n_reg[a])
                                 + NUM_W'(pa1n2_reg[a]);
                num_reg[a][1] <= (NUM_W'(a3_reg[a]) <<< 2) + (NUM_W'(a3_reg[a]) <<< 1)
                                 + (NUM_W'(pa2n_reg[a]) <<< 1);
                num_reg[a][2] <= (NUM_W'(a3_reg[a]) <<< 2) + (NUM_W'(a3_reg[a]) <<< 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividers and the cell chains, one chain per axis
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] quot      [bfd_pkg::NUM_AXES][bfd_pkg::NUM_DIFFS];
    logic [ACC_W-1:0] cell_val  [bfd_pkg::NUM_AXES][bfd_pkg::NUM_CELLS];
    logic [ACC_W-1:0] cell_load [bfd_pkg::NUM_AXES][bfd_pkg::NUM_CELLS];
    logic [ACC_W-1:0] cell_nb   [bfd_pkg::NUM_AXES][bfd_pkg::NUM_CELLS];

    for (genvar a = 0; a < bfd_pkg::NUM_AXES; a++) begin : g_axis
        for (genvar d = 0; d < bfd_pkg::NUM_DIFFS; d++) begin : g_div
            bfd_div #(
                .NUM_W     (NUM_W),
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .aclk (aclk),
                .ctrl (div_ctrl),
                .num  (num_reg[a][d]),
                .den  (n3_reg),
                .quot (quot[a][d])
            );
        end

        for (genvar k = 0; k < bfd_pkg::NUM_CELLS; k++) begin : g_cell
            // start point is P0 scaled exactly; differences come from the dividers
            if (k == 0) begin : g_pos
                assign cell_load[a][k] = ACC_W'(coord[bfd_pkg::REG_POINT_0][a]) << FRAC_BITS;
            end else begin : g_diff
                assign cell_load[a][k] = (n_reg == '0) ? '0 : quot[a][k-1];
            end

            if (k == bfd_pkg::NUM_CELLS - 1) begin : g_tail
                assign cell_nb[a][k] = '0;
            end else begin : g_link
                assign cell_nb[a][k] = cell_val[a][k+1];
            end

            bfd_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .load_value (cell_load[a][k]),
                .neighbour  (cell_nb[a][k]),
                .value      (cell_val[a][k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic signed [COORD_BITS-1:0] out_z_reg;
    logic [SEG_W-1:0]             step_index_reg;
    logic                         last_reg;

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg      <= round_sat(cell_val[0][0]);
            out_y_reg      <= round_sat(cell_val[1][0]);
            out_z_reg      <= round_sat(cell_val[2][0]);
            step_index_reg <= idx_reg;
            last_reg       <= (idx_reg == n_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = out_x_reg;
    assign m_out_y      = out_y_reg;
    assign m_out_z      = out_z_reg;
    assign m_step_index = step_index_reg;
    assign m_last       = last_reg;

endmodule

// ===== design/bfd_checker.sv =====
module bfd_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_BITS-1:0]  m_out_x,
    input logic [bfd_pkg::SEG_W-1:0]     m_step_index,
    input logic                          m_last
);

    // A stalled point holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_step_index)
                                && $stable(m_last))
        else $error("point changed while stalled");

    // Within a run, points follow back to back with increasing index
    a_run_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid
                                          && (m_step_index == $past(m_step_index) + 1'b1))
        else $error("gap or index skip inside a run");

    // Nothing follows the final point until the next request is set up
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("point after end of run");

    // A new request is only taken when no point is pending other than the final one
    a_req_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_last)
        else $error("request taken mid-run");

    // One request at a time
    a_req_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken during setup");

endmodule

bind bezier_forward_difference bfd_checker #(
    .COORD_BITS (COORD_BITS)
) u_bfd_checker (.*);
